/* hdl/nps_pkg.sv */
// Shared constants and controller/datapath interface types for the nth-prime sieve.
`timescale 1ns / 1ps
package nps_pkg;

  localparam int unsigned DefaultSieveSize = 4096;
  localparam int unsigned ValueWidth       = 12;
  localparam int unsigned ValueMax         = 4095;
  localparam int unsigned FirstPrime       = 2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture index, reset address and candidate
    logic clr_wr;     // clear one bitmap entry, advance address
    logic sq_rd;      // square the candidate and read its bitmap entry
    logic i_inc;      // next candidate
    logic m_init;     // first multiple is the square
    logic mark;       // mark current multiple, step by candidate
    logic scan_init;  // start the scan at the first prime
    logic scan_rd;    // read entry at scan address
    logic scan_step;  // count an unmarked entry, advance address
    logic finish;     // latch the result
  } nps_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic sq_in_range;
    logic marked;
    logic m_in_range;
    logic hit;
    logic scan_end;
  } nps_stat_t;

endpackage

/* hdl/nps_datapath.sv */
// Datapath: composite bitmap memory, sieve pointers, scan counter and result registers.
`timescale 1ns / 1ps
module nps_datapath
  import nps_pkg::*;
#(
  parameter int unsigned SIEVE_SIZE = DefaultSieveSize
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nps_cmd_t              cmd,
  output nps_stat_t             stat,
  input  logic [ValueWidth-1:0] in_prime_index,
  output logic [ValueWidth-1:0] out_prime_value,
  output logic                  out_status
);

  localparam int unsigned AW   = $clog2(SIEVE_SIZE);
  localparam int unsigned CW   = AW + 1;
  localparam int unsigned CMPW = (CW > ValueWidth) ? CW : ValueWidth;

  logic                  mem [SIEVE_SIZE];
  logic                  rd_r;
  logic [AW-1:0]         idx_r;
  logic [AW-1:0]         i_r;
  logic [2*AW-1:0]       sq_r;
  logic [AW:0]           m_r;
  logic [CW-1:0]         count_r;
  logic [ValueWidth-1:0] n_r;
  logic [ValueWidth-1:0] value_r;
  logic                  status_r;
  logic [CMPW-1:0]       count_inc;
  logic                  fits;

  assign count_inc = CMPW'(count_r) + CMPW'(1);
  assign fits      = (32'(idx_r) <= 32'(ValueMax));

  assign stat.clr_done    = (idx_r == AW'(SIEVE_SIZE - 1));
  assign stat.sq_in_range = (sq_r < (2*AW)'(SIEVE_SIZE));
  assign stat.marked      = rd_r;
  assign stat.m_in_range  = (m_r < (AW+1)'(SIEVE_SIZE));
  assign stat.hit         = !rd_r && (count_inc == CMPW'(n_r));
  assign stat.scan_end    = (idx_r == AW'(SIEVE_SIZE - 1));

  // Single-port bitmap, registered read
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[idx_r] <= 1'b0;
    end else if (cmd.mark) begin
      mem[m_r[AW-1:0]] <= 1'b1;
    end
    if (cmd.sq_rd) begin
      rd_r <= mem[i_r];
    end else if (cmd.scan_rd) begin
      rd_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r      <= '0;
      idx_r    <= '0;
      i_r      <= '0;
      sq_r     <= '0;
      m_r      <= '0;
      count_r  <= '0;
      value_r  <= '0;
      status_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        n_r   <= in_prime_index;
        idx_r <= '0;
        i_r   <= AW'(FirstPrime);
      end
      if (cmd.clr_wr) begin
        idx_r <= idx_r + AW'(1);
      end
      if (cmd.sq_rd) begin
        sq_r <= (2*AW)'(i_r) * (2*AW)'(i_r);
      end
      if (cmd.i_inc) begin
        i_r <= i_r + AW'(1);
      end
      if (cmd.m_init) begin
        m_r <= sq_r[AW:0];
      end
      if (cmd.mark) begin
        m_r <= m_r + {1'b0, i_r};
      end
      if (cmd.scan_init) begin
        idx_r   <= AW'(FirstPrime);
        count_r <= '0;
      end
      if (cmd.scan_step) begin
        idx_r <= idx_r + AW'(1);
        if (!rd_r) begin
          count_r <= count_r + CW'(1);
        end
      end
      if (cmd.finish) begin
        // a prime that does not fit the result field counts as not found
        if (stat.hit && fits) begin
          value_r  <= ValueWidth'(idx_r);
          status_r <= 1'b0;
        end else begin
          value_r  <= '0;
          status_r <= 1'b1;
        end
      end
    end
  end

  assign out_prime_value = value_r;
  assign out_status      = status_r;

endmodule

/* hdl/nps_ctrl.sv */
// Controller: sequences clear, sieve and scan phases and the start/busy/valid handshake.
`timescale 1ns / 1ps
module nps_ctrl
  import nps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output logic      out_valid,
  output nps_cmd_t  cmd,
  input  nps_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SQ,
    S_TEST,
    S_MARK,
    S_SCAN_RD,
    S_SCAN_CHK
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_done) begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq_rd = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        priority if (!stat.sq_in_range) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN_RD;
        end else if (stat.marked) begin
          cmd.i_inc = 1'b1;
          state_nxt = S_SQ;
        end else begin
          cmd.m_init = 1'b1;
          state_nxt  = S_MARK;
        end
      end
      S_MARK: begin
        if (stat.m_in_range) begin
          cmd.mark = 1'b1;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_step = 1'b1;
        if (stat.hit || stat.scan_end) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.finish;
      if (cmd.load) begin
        busy_r <= 1'b1;
      end else if (cmd.finish) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

/* hdl/nth_prime_sieve_unit.sv */
// Top level of the nth-prime sieve: controller plus datapath.
`timescale 1ns / 1ps
// Returns the n-th prime (n = in_prime_index, 1 selects 2) from a sieve of
// Eratosthenes over a SIEVE_SIZE-entry composite bitmap held in a
// single-port memory.
// Input: an item is taken at a clock edge with start high and busy low;
// busy stays high until the result is delivered.
// Output: out_valid is high for exactly one cycle with out_prime_value and
// out_status (0 found, 1 beyond the sieve or index zero; value is then 0).
// The receiver cannot stall; the result must be taken in that cycle.
// Sequence, set by the one memory port: clear every entry of the bitmap,
// then for each candidate whose square is below SIEVE_SIZE read its entry
// and, if unmarked, mark its multiples from its square upward, then scan
// the entries from 2 and count unmarked ones up to the answer. One item at
// a time; a new start is taken in the cycle out_valid is high. Reset
// returns the controller to idle and drops any item in progress; the
// bitmap needs no reset since every item clears it first.
module nth_prime_sieve_unit
  import nps_pkg::*;
#(
  parameter int unsigned SIEVE_SIZE = DefaultSieveSize
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [ValueWidth-1:0] in_prime_index,
  output logic                  out_valid,
  output logic [ValueWidth-1:0] out_prime_value,
  output logic                  out_status
);

  nps_cmd_t  cmd;
  nps_stat_t stat;

  nps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  nps_datapath #(
    .SIEVE_SIZE (SIEVE_SIZE)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_prime_index  (in_prime_index),
    .out_prime_value (out_prime_value),
    .out_status      (out_status)
  );

endmodule

/* hdl/nps_checker.sv */
// Port-level assertions for the nth-prime sieve, bound to the top level.
`timescale 1ns / 1ps
module nps_checker
  import nps_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [ValueWidth-1:0] out_prime_value,
  input logic                  out_status
);

  // A taken item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after item accepted");

  // Result strobe lasts one cycle
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid longer than one cycle");

  // Result only once the block has gone idle
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result outside end of item");

  // Leaving busy always delivers a result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("item finished without result");

  // Not-found results carry a zero value
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_prime_value == '0)
    else $error("nonzero value with not-found status");

endmodule

bind nth_prime_sieve_unit nps_checker u_nps_checker (.*);
